/* hw/rtl/i2c_master_write_engine_defines.svh */
// assertion macros used by the i2c master write engine checker
`ifndef I2C_MASTER_WRITE_ENGINE_DEFINES_SVH
`define I2C_MASTER_WRITE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define I2CMWE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define I2CMWE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/i2cmwe_pkg.sv */
// types and constants of the i2c master write engine
`default_nettype none

package i2cmwe_pkg;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_ST_SCL_HI  = 4'd1,
		PH_ST_SDA_HI  = 4'd2,
		PH_ST_SDA_LO  = 4'd3,
		PH_ST_SCL_LO  = 4'd4,
		PH_BIT_SDA    = 4'd5,
		PH_BIT_SCL_HI = 4'd6,
		PH_BIT_SCL_LO = 4'd7,
		PH_AK_SCL_LO  = 4'd8,
		PH_AK_SDA_HI  = 4'd9,
		PH_AK_SCL_HI  = 4'd10,
		PH_AK_POLL    = 4'd11,
		PH_AK_TAIL    = 4'd12,
		PH_SP_SDA_LO  = 4'd13,
		PH_SP_SCL_HI  = 4'd14,
		PH_SP_SDA_HI  = 4'd15
	} phase_t;

	localparam int unsigned PhaseW = 16;
	localparam int unsigned PollW  = 8;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PHASE_TICKS = 2'd0;
	localparam cfg_idx_t CFG_ACK_POLL    = 2'd1;

	localparam logic [PhaseW-1:0] PHASE_TICKS_RST = 16'd72;
	localparam logic [PollW-1:0]  ACK_POLL_RST    = 8'd100;

endpackage

`default_nettype wire

/* hw/rtl/i2c_master_write_engine.sv */
// i2c master write engine: per-tick scl/sda sequencer for one byte with ack
// Usage:
//   Input channel (in_valid/in_stall) carries one clock tick per transfer:
//   action, tx_byte, with_start, with_stop and the sampled sda_in. A tick with
//   action set while the engine is idle starts a byte, optionally framed by a
//   start and/or stop condition; action is ignored while busy.
//   Output channel (out_valid/out_stall) returns one result per tick: the scl
//   and sda drive levels after that tick, ready_res, and a byte_done pulse with
//   ack_missing when the acknowledge slot ends.
//   Config channel (cfg_valid/cfg_ready, always ready) writes phase_ticks
//   (index 0) and ack_poll_limit (index 1); other indexes are ignored.
// Timing:
//   a tick lands in the input register, is stepped through the phase logic and
//   the result is registered; one tick per cycle sustained while out_stall does
//   not hold the result. The engine state registers are the only loop.
//   When out_stall holds the result, the input register holds too and in_stall
//   rises; nothing is dropped. Reset (arst_n low) puts the engine idle with both
//   lines released and the registers at 72 and 100.
`default_nettype none

module i2c_master_write_engine (
	input  wire                         clk,
	input  wire                         arst_n,
	// input ticks
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         action,
	input  wire  [7:0]                  tx_byte,
	input  wire                         with_start,
	input  wire                         with_stop,
	input  wire                         sda_in,
	// results
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic                        scl_out,
	output logic                        sda_out,
	output logic                        ready_res,
	output logic                        byte_done,
	output logic                        ack_missing,
	// configuration writes
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  i2cmwe_pkg::cfg_idx_t  cfg_index,
	input  wire  [15:0]                 cfg_data
);
	import i2cmwe_pkg::*;

	// configuration registers
	logic [PhaseW-1:0] phase_ticks_q;
	logic [PollW-1:0]  ack_poll_q;

	// input register
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] tx_byte_s1;
	logic       with_start_s1;
	logic       with_stop_s1;
	logic       sda_in_s1;

	// engine state
	phase_t            state_q;
	logic [2:0]        bit_q;
	logic [7:0]        shift_q;
	logic [PhaseW-1:0] delay_q;
	logic [PollW-1:0]  poll_q;
	logic              stop_q;
	logic              scl_q;
	logic              sda_q;

	phase_t            nxt_state;
	logic [2:0]        nxt_bit;
	logic [7:0]        nxt_shift;
	logic [PhaseW-1:0] nxt_delay;
	logic [PollW-1:0]  nxt_poll;
	logic              nxt_stop;
	logic              nxt_scl;
	logic              nxt_sda;
	logic              done;
	logic              missing;
	logic              over;
	logic [PollW-1:0]  poll_inc;

	logic adv;
	logic proc;

	assign cfg_ready = 1'b1;

	// result register free or being taken this cycle
	assign adv      = !out_valid || !out_stall;
	assign proc     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_poll_q    <= ACK_POLL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PHASE_TICKS: phase_ticks_q <= cfg_data;
				CFG_ACK_POLL:    ack_poll_q    <= cfg_data[PollW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1     <= action;
			tx_byte_s1    <= tx_byte;
			with_start_s1 <= with_start;
			with_stop_s1  <= with_stop;
			sda_in_s1     <= sda_in;
		end
	end

	assign over     = (delay_q <= 16'd1);
	assign poll_inc = poll_q + 8'd1;

	always_comb begin
		nxt_state = state_q;
		nxt_bit   = bit_q;
		nxt_shift = shift_q;
		nxt_delay = delay_q;
		nxt_poll  = poll_q;
		nxt_stop  = stop_q;
		nxt_scl   = scl_q;
		nxt_sda   = sda_q;
		done      = 1'b0;
		missing   = 1'b0;

		// timed phases count down until the phase ends
		if (state_q != PH_IDLE && state_q != PH_AK_POLL && !over) begin
			nxt_delay = delay_q - 16'd1;
		end

		case (state_q)
			PH_IDLE: begin
				if (action_s1) begin
					nxt_shift = tx_byte_s1;
					nxt_stop  = with_stop_s1;
					nxt_bit   = 3'd0;
					nxt_state = with_start_s1 ? PH_ST_SCL_HI : PH_BIT_SDA;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_ST_SCL_HI: begin
				if (over) begin
					nxt_scl   = 1'b1;
					nxt_state = PH_ST_SDA_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_ST_SDA_HI: begin
				if (over) begin
					nxt_sda   = 1'b1;
					nxt_state = PH_ST_SDA_LO;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_ST_SDA_LO: begin
				if (over) begin
					nxt_sda   = 1'b0;
					nxt_state = PH_ST_SCL_LO;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_ST_SCL_LO: begin
				if (over) begin
					nxt_scl   = 1'b0;
					nxt_state = PH_BIT_SDA;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_BIT_SDA: begin
				if (over) begin
					nxt_sda   = shift_q[7];
					nxt_state = PH_BIT_SCL_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_BIT_SCL_HI: begin
				if (over) begin
					nxt_scl   = 1'b1;
					nxt_state = PH_BIT_SCL_LO;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_BIT_SCL_LO: begin
				if (over) begin
					nxt_scl   = 1'b0;
					nxt_shift = {shift_q[6:0], 1'b0};
					nxt_delay = phase_ticks_q;
					if (bit_q == 3'd7) begin
						nxt_bit   = 3'd0;
						nxt_state = PH_AK_SCL_LO;
					end else begin
						nxt_bit   = bit_q + 3'd1;
						nxt_state = PH_BIT_SDA;
					end
				end
			end
			PH_AK_SCL_LO: begin
				if (over) begin
					nxt_scl   = 1'b0;
					nxt_state = PH_AK_SDA_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_AK_SDA_HI: begin
				if (over) begin
					nxt_sda   = 1'b1;
					nxt_state = PH_AK_SCL_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_AK_SCL_HI: begin
				if (over) begin
					nxt_scl   = 1'b1;
					nxt_poll  = '0;
					nxt_state = PH_AK_POLL;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_AK_POLL: begin
				if (!sda_in_s1) begin
					nxt_bit   = 3'd0;
					nxt_state = PH_AK_TAIL;
					nxt_delay = phase_ticks_q;
				end else begin
					nxt_poll = poll_inc;
					// a zero limit acts as one poll tick
					if (poll_inc >= ack_poll_q || poll_inc == '0) begin
						nxt_scl   = 1'b0;
						done      = 1'b1;
						missing   = 1'b1;
						nxt_bit   = 3'd0;
						nxt_state = stop_q ? PH_SP_SDA_LO : PH_IDLE;
						nxt_delay = phase_ticks_q;
					end
				end
			end
			PH_AK_TAIL: begin
				// two phase delays after the ack, bit_q marks the second
				if (over) begin
					nxt_delay = phase_ticks_q;
					if (bit_q == 3'd0) begin
						nxt_bit = 3'd1;
					end else begin
						nxt_scl   = 1'b0;
						done      = 1'b1;
						nxt_bit   = 3'd0;
						nxt_state = stop_q ? PH_SP_SDA_LO : PH_IDLE;
					end
				end
			end
			PH_SP_SDA_LO: begin
				if (over) begin
					nxt_sda   = 1'b0;
					nxt_state = PH_SP_SCL_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_SP_SCL_HI: begin
				if (over) begin
					nxt_scl   = 1'b1;
					nxt_state = PH_SP_SDA_HI;
					nxt_delay = phase_ticks_q;
				end
			end
			PH_SP_SDA_HI: begin
				if (over) begin
					nxt_sda   = 1'b1;
					nxt_stop  = 1'b0;
					nxt_state = PH_IDLE;
					nxt_delay = phase_ticks_q;
				end
			end
			default: begin
				nxt_state = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			delay_q <= '0;
			poll_q  <= '0;
			stop_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (proc) begin
			state_q <= nxt_state;
			bit_q   <= nxt_bit;
			shift_q <= nxt_shift;
			delay_q <= nxt_delay;
			poll_q  <= nxt_poll;
			stop_q  <= nxt_stop;
			scl_q   <= nxt_scl;
			sda_q   <= nxt_sda;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			scl_out     <= nxt_scl;
			sda_out     <= nxt_sda;
			ready_res   <= (nxt_state == PH_IDLE);
			byte_done   <= done;
			ack_missing <= missing;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/i2cmwe_checker.sv */
// port-level checks of the i2c master write engine, bound to the top level
`default_nettype none

`include "i2c_master_write_engine_defines.svh"

module i2cmwe_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_stall,
	input wire                         out_valid,
	input wire                         out_stall,
	input wire                         scl_out,
	input wire                         sda_out,
	input wire                         ready_res,
	input wire                         byte_done,
	input wire                         ack_missing
);
	logic [4:0] res_bits;

	assign res_bits = {scl_out, sda_out, ready_res, byte_done, ack_missing};

	// a stalled result stays and keeps its payload
	`I2CMWE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_bits), "result changed while stalled")

	// the input only backs up behind a held result
	`I2CMWE_ASSERT_NOW(a_in_stall, in_stall, out_valid && out_stall, "input stalled with result register free")

	`I2CMWE_ASSERT_NOW(a_miss_done, out_valid && ack_missing, byte_done, "ack_missing without byte_done")

	// the ack slot always ends with scl pulled low
	`I2CMWE_ASSERT_NOW(a_done_scl, out_valid && byte_done, !scl_out, "byte_done with scl released")

	// ending a byte without stop leaves sda released
	`I2CMWE_ASSERT_NOW(a_done_idle_sda, out_valid && byte_done && ready_res, sda_out, "idle after byte with sda low")

endmodule

bind i2c_master_write_engine i2cmwe_checker u_i2cmwe_checker (.*);

`default_nettype wire
